// ===== rtl/core/bmi_pkg.sv =====
// bmi_pkg: shared types, codes and widths of the brake map interpolator
package bmi_pkg;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int IDX_W     = 4;
   localparam int STATUS_W  = 2;
   localparam int CNT_REG_W = 5;
   localparam int RATIO_W   = 31;
   localparam int FRAC_W    = 30;
   localparam int DIV_STEPS = 62;
   localparam int DIV_CNT_W = 6;

   localparam logic [OP_W-1:0] OP_WR_VEL   = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_BRAKE = 3'd1;
   localparam logic [OP_W-1:0] OP_WR_MAP   = 3'd2;
   localparam logic [OP_W-1:0] OP_BRAKE_Q  = 3'd3;
   localparam logic [OP_W-1:0] OP_ACCEL_Q  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_WRITE  = 2'd3;

   localparam logic CSR_VEL_POINTS   = 1'b0;
   localparam logic CSR_BRAKE_POINTS = 1'b1;

   typedef enum logic [1:0] {TBL_VAX, TBL_BAX, TBL_MAP, TBL_ACC} tbl_type;
   typedef enum logic [1:0] {Q_HOLD, Q_VEL_CLAMP, Q_QV_CLAMP, Q_QV} q_src_type;
   typedef enum logic [1:0] {RES_HOLD, RES_ZERO, RES_RD, RES_INTERP} res_src_type;

   typedef struct packed {
      logic                in_ld;
      logic                rd_en;
      tbl_type             rd_sel;
      logic                ld_x0;
      logic                ld_x1;
      q_src_type           q_src;
      logic                div_start;
      logic                ld_y0;
      logic                ld_mag;
      logic                ld_mul;
      logic                acc_wr;
      res_src_type         res_src;
      logic                out_ld;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic rd_lt_q;
      logic div_busy;
      logic qv_lt_x0;
      logic x1_lt_qv;
   } sts_type;

endpackage

// ===== rtl/core/bmi_if.sv =====
// bmi_if: request, response and register write channels
interface bmi_req_if import bmi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         column_index;
   logic signed [DATA_W-1:0] write_value;
   logic signed [DATA_W-1:0] velocity;
   logic signed [DATA_W-1:0] query_value;
   modport source (output valid, op, row_index, column_index, write_value, velocity,
                   query_value, input ready);
   modport sink (input valid, op, row_index, column_index, write_value, velocity,
                 query_value, output ready);
endinterface

interface bmi_rsp_if import bmi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [STATUS_W-1:0]      status;
   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface

interface bmi_csr_if import bmi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 index;
   logic [CNT_REG_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bmi_datapath.sv =====
// bmi_datapath: table memories, working registers, divider and interpolation arithmetic
module bmi_datapath import bmi_pkg::*; #(
   parameter int MAX_VELOCITY_POINTS = 16,
   parameter int MAX_BRAKE_POINTS    = 16,
   localparam int VIW = $clog2(MAX_VELOCITY_POINTS),
   localparam int BIW = $clog2(MAX_BRAKE_POINTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [BIW-1:0]           rd_row,
   input  logic [VIW-1:0]           rd_col,
   input  logic [OP_W-1:0]          in_op,
   input  logic [IDX_W-1:0]         in_row,
   input  logic [IDX_W-1:0]         in_col,
   input  logic signed [DATA_W-1:0] in_wv,
   input  logic signed [DATA_W-1:0] in_vel,
   input  logic signed [DATA_W-1:0] in_qv,
   output logic signed [DATA_W-1:0] out_value,
   output logic [STATUS_W-1:0]      out_status
);
   localparam int MAW = $clog2(MAX_VELOCITY_POINTS * MAX_BRAKE_POINTS);
   localparam int MAP_DEPTH = MAX_VELOCITY_POINTS * MAX_BRAKE_POINTS;

   logic signed [DATA_W-1:0] vax_mem [MAX_VELOCITY_POINTS];
   logic signed [DATA_W-1:0] bax_mem [MAX_BRAKE_POINTS];
   logic signed [DATA_W-1:0] map_mem [MAP_DEPTH];
   logic signed [DATA_W-1:0] acc_mem [MAX_BRAKE_POINTS];
   logic signed [DATA_W-1:0] vax_rd_ff, bax_rd_ff, map_rd_ff, acc_rd_ff;
   tbl_type                  rdsel_ff;
   logic signed [DATA_W-1:0] rdata;

   logic signed [DATA_W-1:0] vel_ff, qv_ff, q_ff, x0_ff, x1_ff, y0_ff, res_ff;
   logic signed [DATA_W-1:0] q_in, res_in;
   logic [DATA_W-1:0]        mag_ff;
   logic                     neg_ff;
   logic [RATIO_W-1:0]       ratio_ff;
   logic [2*DATA_W-2:0]      prod_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic [STATUS_W-1:0]      out_status_ff;

   logic [2*DATA_W-3:0]      divd_ff;
   logic [DATA_W-1:0]        dvs_ff, rem_ff;
   logic [DIV_CNT_W-1:0]     dcnt_ff;
   logic                     busy_ff, degen_ff;

   logic                     vax_we, bax_we, map_we;
   logic [VIW-1:0]           wr_col;
   logic [BIW-1:0]           wr_row;
   logic [MAW-1:0]           wr_maddr, rd_maddr;

   logic signed [DATA_W:0]   dx33, dq33, dy33;
   logic [DATA_W:0]          dq_sat, mag33;
   logic                     degen;
   logic [DATA_W:0]          rem2;
   logic                     ge;
   logic [2*DATA_W-3:0]      quo_next;
   logic [2*DATA_W-1:0]      rnd;
   logic signed [DATA_W+1:0] d34, interp34;
   logic signed [DATA_W-1:0] interp;

   function automatic logic signed [DATA_W-1:0] clamp_to(
      input logic signed [DATA_W-1:0] v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi);
      logic signed [DATA_W-1:0] r;
      if (v < lo) r = lo;
      else if (hi < v) r = hi;
      else r = v;
      return r;
   endfunction

   // write decode, out-of-range indexes are dropped
   assign wr_col   = VIW'(in_col);
   assign wr_row   = BIW'(in_row);
   assign vax_we   = cmd.in_ld && in_op == OP_WR_VEL && int'(in_col) < MAX_VELOCITY_POINTS;
   assign bax_we   = cmd.in_ld && in_op == OP_WR_BRAKE && int'(in_row) < MAX_BRAKE_POINTS;
   assign map_we   = cmd.in_ld && in_op == OP_WR_MAP && int'(in_row) < MAX_BRAKE_POINTS &&
                     int'(in_col) < MAX_VELOCITY_POINTS;
   assign wr_maddr = MAW'(MAW'(wr_row) * MAW'(MAX_VELOCITY_POINTS)) + MAW'(wr_col);
   assign rd_maddr = MAW'(MAW'(rd_row) * MAW'(MAX_VELOCITY_POINTS)) + MAW'(rd_col);

   always_ff @(posedge clock) begin
      if (vax_we) vax_mem[wr_col] <= in_wv;
      if (cmd.rd_en && cmd.rd_sel == TBL_VAX) vax_rd_ff <= vax_mem[rd_col];
   end

   always_ff @(posedge clock) begin
      if (bax_we) bax_mem[wr_row] <= in_wv;
      if (cmd.rd_en && cmd.rd_sel == TBL_BAX) bax_rd_ff <= bax_mem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[wr_maddr] <= in_wv;
      if (cmd.rd_en && cmd.rd_sel == TBL_MAP) map_rd_ff <= map_mem[rd_maddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_wr) acc_mem[rd_row] <= interp;
      if (cmd.rd_en && cmd.rd_sel == TBL_ACC) acc_rd_ff <= acc_mem[rd_row];
   end

   always_comb begin
      unique case (rdsel_ff)
         TBL_VAX: rdata = vax_rd_ff;
         TBL_BAX: rdata = bax_rd_ff;
         TBL_MAP: rdata = map_rd_ff;
         TBL_ACC: rdata = acc_rd_ff;
         default: rdata = vax_rd_ff;
      endcase
   end

   // segment setup for the divider
   always_comb begin
      dx33   = {x1_ff[DATA_W-1], x1_ff} - {x0_ff[DATA_W-1], x0_ff};
      degen  = !(x0_ff < x1_ff);
      dq33   = {q_ff[DATA_W-1], q_ff} - {x0_ff[DATA_W-1], x0_ff};
      if (q_ff <= x0_ff) dq_sat = '0;
      else if (dq33 > dx33) dq_sat = dx33;
      else dq_sat = dq33;
   end

   // restoring divider, one quotient bit a cycle
   assign rem2     = {rem_ff, divd_ff[2*DATA_W-3]};
   assign ge       = rem2 >= {1'b0, dvs_ff};
   assign quo_next = {divd_ff[2*DATA_W-4:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         dcnt_ff <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (dcnt_ff == DIV_CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         divd_ff  <= {dq_sat[DATA_W-1:0], {FRAC_W{1'b0}}};
         dvs_ff   <= dx33[DATA_W-1:0];
         rem_ff   <= '0;
         degen_ff <= degen;
      end else if (busy_ff) begin
         divd_ff <= quo_next;
         rem_ff  <= ge ? DATA_W'(rem2 - {1'b0, dvs_ff}) : rem2[DATA_W-1:0];
         if (dcnt_ff == DIV_CNT_W'(1)) ratio_ff <= degen_ff ? '0 : quo_next[RATIO_W-1:0];
      end
   end

   // interpolation: y0 +/- round(|dy| * ratio / 2^30)
   assign dy33     = {rdata[DATA_W-1], rdata} - {y0_ff[DATA_W-1], y0_ff};
   assign mag33    = dy33[DATA_W] ? (DATA_W+1)'(0) - dy33 : dy33;
   assign rnd      = {1'b0, prod_ff} + (2*DATA_W)'(64'h2000_0000);
   assign d34      = $signed({1'b0, rnd[2*DATA_W-2:FRAC_W]});
   assign interp34 = neg_ff ? {{2{y0_ff[DATA_W-1]}}, y0_ff} - d34
                            : {{2{y0_ff[DATA_W-1]}}, y0_ff} + d34;
   assign interp   = interp34[DATA_W-1:0];

   always_comb begin
      unique case (cmd.q_src)
         Q_HOLD:      q_in = q_ff;
         Q_VEL_CLAMP: q_in = clamp_to(vel_ff, x0_ff, x1_ff);
         Q_QV_CLAMP:  q_in = clamp_to(qv_ff, x0_ff, x1_ff);
         Q_QV:        q_in = qv_ff;
         default:     q_in = q_ff;
      endcase
      unique case (cmd.res_src)
         RES_HOLD:   res_in = res_ff;
         RES_ZERO:   res_in = '0;
         RES_RD:     res_in = rdata;
         RES_INTERP: res_in = interp;
         default:    res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdsel_ff <= cmd.rd_sel;
      if (cmd.in_ld) begin
         vel_ff <= in_vel;
         qv_ff  <= in_qv;
      end
      q_ff   <= q_in;
      res_ff <= res_in;
      if (cmd.ld_x0) x0_ff <= rdata;
      if (cmd.ld_x1) x1_ff <= rdata;
      if (cmd.ld_y0) y0_ff <= rdata;
      if (cmd.ld_mag) begin
         mag_ff <= mag33[DATA_W-1:0];
         neg_ff <= dy33[DATA_W];
      end
      if (cmd.ld_mul) prod_ff <= {{(DATA_W-1){1'b0}}, mag_ff} * {{DATA_W{1'b0}}, ratio_ff};
      if (cmd.out_ld) begin
         out_value_ff  <= res_ff;
         out_status_ff <= cmd.status;
      end
   end

   assign sts.rd_lt_q  = rdata < q_ff;
   assign sts.div_busy = busy_ff;
   assign sts.qv_lt_x0 = qv_ff < x0_ff;
   assign sts.x1_lt_qv = x1_ff < qv_ff;

   assign out_value  = out_value_ff;
   assign out_status = out_status_ff;

endmodule

// ===== rtl/core/bmi_controller.sv =====
// bmi_controller: sequencer for table writes, segment search, division and row interpolation
module bmi_controller import bmi_pkg::*; #(
   parameter int MAX_VELOCITY_POINTS = 16,
   parameter int MAX_BRAKE_POINTS    = 16,
   localparam int VIW = $clog2(MAX_VELOCITY_POINTS),
   localparam int BIW = $clog2(MAX_BRAKE_POINTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [CNT_REG_W-1:0] csr_data,
   output cmd_type              cmd,
   input  sts_type              sts,
   output logic [BIW-1:0]       rd_row,
   output logic [VIW-1:0]       rd_col
);
   localparam int CVW = $clog2(MAX_VELOCITY_POINTS + 1);
   localparam int CBW = $clog2(MAX_BRAKE_POINTS + 1);
   localparam int NW  = (CVW > CBW) ? CVW : CBW;

   typedef enum logic [24:0] {
      S_IDLE  = 25'b1 << 0,  S_V0   = 25'b1 << 1,  S_V1   = 25'b1 << 2,
      S_V2    = 25'b1 << 3,  S_V3   = 25'b1 << 4,  S_SRD  = 25'b1 << 5,
      S_SCMP  = 25'b1 << 6,  S_DIV  = 25'b1 << 7,  S_DWAIT = 25'b1 << 8,
      S_YRD0  = 25'b1 << 9,  S_YRD1 = 25'b1 << 10, S_YMAG = 25'b1 << 11,
      S_YMUL  = 25'b1 << 12, S_YFIN = 25'b1 << 13, S_B0   = 25'b1 << 14,
      S_B1    = 25'b1 << 15, S_B2   = 25'b1 << 16, S_B3   = 25'b1 << 17,
      S_A0    = 25'b1 << 18, S_A1   = 25'b1 << 19, S_A2   = 25'b1 << 20,
      S_A3    = 25'b1 << 21, S_ORD  = 25'b1 << 22, S_OLD  = 25'b1 << 23,
      S_DONE  = 25'b1 << 24
   } state_type;

   typedef enum logic [1:0] {PH_ROWS, PH_OP4, PH_OP3} phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [CNT_REG_W-1:0] vpu_ff, bpu_ff;
   logic [NW-1:0]        k_ff, k_in, i_ff, i_in;
   logic                 op3_ff, op3_in;
   logic [STATUS_W-1:0]  st_ff, st_in;
   logic                 rsp_valid_ff;
   logic [NW-1:0]        nv, nb, n_sel, k1, i1;
   logic [NW-1:0]        rev0, rev1;
   logic                 more;

   // effective point counts
   always_comb begin
      if (vpu_ff < CNT_REG_W'(2)) nv = NW'(2);
      else if (int'(vpu_ff) > MAX_VELOCITY_POINTS) nv = NW'(MAX_VELOCITY_POINTS);
      else nv = NW'(vpu_ff);
      if (bpu_ff < CNT_REG_W'(2)) nb = NW'(2);
      else if (int'(bpu_ff) > MAX_BRAKE_POINTS) nb = NW'(MAX_BRAKE_POINTS);
      else nb = NW'(bpu_ff);
   end

   assign n_sel = (phase_ff == PH_ROWS) ? nv : nb;
   assign k1    = k_ff + NW'(1);
   assign i1    = i_ff + NW'(1);
   assign rev0  = nb - NW'(1) - k_ff;
   assign rev1  = nb - NW'(2) - k_ff;
   assign more  = ({1'b0, k_ff} + (NW+1)'(2)) < {1'b0, n_sel};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      op3_in   = op3_ff;
      st_in    = st_ff;
      cmd      = '0;
      rd_row   = '0;
      rd_col   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.in_ld = 1'b1;
               if (req_op == OP_BRAKE_Q || req_op == OP_ACCEL_Q) begin
                  op3_in   = (req_op == OP_BRAKE_Q);
                  phase_in = PH_ROWS;
                  i_in     = '0;
                  state_in = S_V0;
               end else begin
                  cmd.res_src = RES_ZERO;
                  st_in       = ST_WRITE;
                  state_in    = S_DONE;
               end
            end
         end
         S_V0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_VAX;
            state_in   = S_V1;
         end
         S_V1: begin
            cmd.ld_x0  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_VAX;
            rd_col     = VIW'(nv - NW'(1));
            state_in   = S_V2;
         end
         S_V2: begin
            cmd.ld_x1 = 1'b1;
            state_in  = S_V3;
         end
         S_V3: begin
            cmd.q_src = Q_VEL_CLAMP;
            k_in      = '0;
            state_in  = S_SRD;
         end
         S_SRD: begin
            cmd.rd_en = 1'b1;
            unique case (phase_ff)
               PH_ROWS: begin
                  cmd.rd_sel = TBL_VAX;
                  rd_col     = VIW'(k1);
               end
               PH_OP4: begin
                  cmd.rd_sel = TBL_BAX;
                  rd_row     = BIW'(k1);
               end
               default: begin
                  cmd.rd_sel = TBL_ACC;
                  rd_row     = BIW'(rev1);
               end
            endcase
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (more && sts.rd_lt_q) begin
               cmd.ld_x0 = 1'b1;
               k_in      = k1;
               state_in  = S_SRD;
            end else begin
               cmd.ld_x1 = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (!sts.div_busy) state_in = S_YRD0;
         end
         S_YRD0: begin
            cmd.rd_en = 1'b1;
            unique case (phase_ff)
               PH_ROWS: begin
                  cmd.rd_sel = TBL_MAP;
                  rd_row     = BIW'(i_ff);
                  rd_col     = VIW'(k_ff);
               end
               PH_OP4: begin
                  cmd.rd_sel = TBL_ACC;
                  rd_row     = BIW'(k_ff);
               end
               default: begin
                  cmd.rd_sel = TBL_BAX;
                  rd_row     = BIW'(rev0);
               end
            endcase
            state_in = S_YRD1;
         end
         S_YRD1: begin
            cmd.ld_y0 = 1'b1;
            cmd.rd_en = 1'b1;
            unique case (phase_ff)
               PH_ROWS: begin
                  cmd.rd_sel = TBL_MAP;
                  rd_row     = BIW'(i_ff);
                  rd_col     = VIW'(k1);
               end
               PH_OP4: begin
                  cmd.rd_sel = TBL_ACC;
                  rd_row     = BIW'(k1);
               end
               default: begin
                  cmd.rd_sel = TBL_BAX;
                  rd_row     = BIW'(rev1);
               end
            endcase
            state_in = S_YMAG;
         end
         S_YMAG: begin
            cmd.ld_mag = 1'b1;
            state_in   = S_YMUL;
         end
         S_YMUL: begin
            cmd.ld_mul = 1'b1;
            state_in   = S_YFIN;
         end
         S_YFIN: begin
            if (phase_ff == PH_ROWS) begin
               cmd.acc_wr = 1'b1;
               rd_row     = BIW'(i_ff);
               if (i1 < nb) begin
                  i_in     = i1;
                  state_in = S_YRD0;
               end else begin
                  state_in = op3_ff ? S_A0 : S_B0;
               end
            end else begin
               cmd.res_src = RES_INTERP;
               st_in       = ST_INTERP;
               state_in    = S_DONE;
            end
         end
         S_B0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_BAX;
            state_in   = S_B1;
         end
         S_B1: begin
            cmd.ld_x0  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_BAX;
            rd_row     = BIW'(nb - NW'(1));
            state_in   = S_B2;
         end
         S_B2: begin
            cmd.ld_x1 = 1'b1;
            state_in  = S_B3;
         end
         S_B3: begin
            cmd.q_src = Q_QV_CLAMP;
            k_in      = '0;
            phase_in  = PH_OP4;
            state_in  = S_SRD;
         end
         S_A0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_ACC;
            rd_row     = BIW'(nb - NW'(1));
            state_in   = S_A1;
         end
         S_A1: begin
            cmd.ld_x0  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_ACC;
            state_in   = S_A2;
         end
         S_A2: begin
            cmd.ld_x1 = 1'b1;
            state_in  = S_A3;
         end
         S_A3: begin
            // x0 holds the last row, x1 the first row
            if (sts.qv_lt_x0) begin
               st_in    = ST_BELOW;
               state_in = S_ORD;
            end else if (sts.x1_lt_qv) begin
               st_in    = ST_ABOVE;
               state_in = S_ORD;
            end else begin
               cmd.q_src = Q_QV;
               k_in      = '0;
               phase_in  = PH_OP3;
               state_in  = S_SRD;
            end
         end
         S_ORD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = TBL_BAX;
            rd_row     = (st_ff == ST_BELOW) ? BIW'(nb - NW'(1)) : '0;
            state_in   = S_OLD;
         end
         S_OLD: begin
            cmd.res_src = RES_RD;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld = 1'b1;
               cmd.status = st_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ROWS;
         rsp_valid_ff <= 1'b0;
         vpu_ff       <= CNT_REG_W'(2);
         bpu_ff       <= CNT_REG_W'(2);
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if (cmd.out_ld) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VEL_POINTS:   vpu_ff <= csr_data;
               CSR_BRAKE_POINTS: bpu_ff <= csr_data;
               default:          vpu_ff <= vpu_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      i_ff   <= i_in;
      op3_ff <= op3_in;
      st_ff  <= st_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== rtl/core/brake_map_interpolator.sv =====
// brake_map_interpolator: top level of the two-dimensional brake map lookup
//
//   channel  dir  handshake          payload
//   req_ch   in   valid / ready      op, row_index, column_index, write_value,
//                                    velocity, query_value
//   rsp_ch   out  valid / ready      result_value, status
//   csr_ch   in   valid / ready (=1) index, data
//
// a table write passes from accept through the done state into the output register
// a query's time from accept to result grows with nv and nb;
// its 62-step restoring divisions (up to two per query) and the per-row interpolation set it
// one item is in flight; a new item is taken while the last result waits in the output register
// reset is synchronous, active high; table contents are not cleared
// rsp stalls hold the finished result, the next item completes once the output frees
module brake_map_interpolator import bmi_pkg::*; #(
   parameter int MAX_VELOCITY_POINTS = 16,
   parameter int MAX_BRAKE_POINTS    = 16
) (
   input logic       clock,
   input logic       reset,
   bmi_req_if.sink   req_ch,
   bmi_rsp_if.source rsp_ch,
   bmi_csr_if.sink   csr_ch
);
   localparam int VIW = $clog2(MAX_VELOCITY_POINTS);
   localparam int BIW = $clog2(MAX_BRAKE_POINTS);

   // controller to datapath commands and datapath flags back
   cmd_type        cmd;
   sts_type        sts;
   logic [BIW-1:0] rd_row;
   logic [VIW-1:0] rd_col;

   // sequencer: request accept, search, division wait, row loop, result hand-off
   bmi_controller #(
      .MAX_VELOCITY_POINTS (MAX_VELOCITY_POINTS),
      .MAX_BRAKE_POINTS    (MAX_BRAKE_POINTS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_op    (req_ch.op),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cmd       (cmd),
      .sts       (sts),
      .rd_row    (rd_row),
      .rd_col    (rd_col)
   );

   // memories for axes, map and interpolated row values, plus arithmetic
   bmi_datapath #(
      .MAX_VELOCITY_POINTS (MAX_VELOCITY_POINTS),
      .MAX_BRAKE_POINTS    (MAX_BRAKE_POINTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .rd_row     (rd_row),
      .rd_col     (rd_col),
      .in_op      (req_ch.op),
      .in_row     (req_ch.row_index),
      .in_col     (req_ch.column_index),
      .in_wv      (req_ch.write_value),
      .in_vel     (req_ch.velocity),
      .in_qv      (req_ch.query_value),
      .out_value  (rsp_ch.result_value),
      .out_status (rsp_ch.status)
   );

endmodule

// ===== rtl/core/bmi_checker.sv =====
// bmi_checker: port-level assertions for the brake map interpolator, bound to the top level
module bmi_checker import bmi_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_result_value,
   input logic [STATUS_W-1:0]      rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_WRITE |-> rsp_result_value == '0)
      else $error("write response carries a nonzero value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind brake_map_interpolator bmi_checker u_bmi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);
